// ===== rtl/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants of the packed-decimal text converter
// Holds the job record passed from the byte front end to the text back end,
// the digit store write command, register indexes and character codes.
// ----------------------------------------------------------------------------
package pdt_pkg;

  // Digit capacity of one field
  localparam int MAX_DIGITS_DEF = 31;
  localparam int DIGIT_DEPTH    = 32;
  localparam int BANK_DEPTH     = DIGIT_DEPTH / 2;
  localparam int BANK_AW        = $clog2(BANK_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] CFG_INTEGER_DIGITS  = 2'd0;
  localparam logic [1:0] CFG_FRACTION_DIGITS = 2'd1;
  localparam logic [1:0] CFG_SIGNED_FIELD    = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_POINT = 8'h2e;
  localparam logic [3:0] NIB_NEG    = 4'hd;

  // One finished field waiting for text output
  typedef struct packed {
    logic       bank;
    logic       sgn;
    logic       neg;
    logic [4:0] intd;
    logic [4:0] frac;
    logic [4:0] total;
  } job_t;

  // Digit store write command: one even and one odd digit per beat
  typedef struct packed {
    logic               bank;
    logic               ev_en;
    logic [BANK_AW-1:0] ev_addr;
    logic [3:0]         ev_data;
    logic               od_en;
    logic [BANK_AW-1:0] od_addr;
    logic [3:0]         od_data;
  } dwr_t;

endpackage

// ===== rtl/pdt_front.sv =====
// ----------------------------------------------------------------------------
// pdt_front: byte intake of the packed-decimal text converter
// Holds the configuration registers, counts bytes of the field, splits each
// byte into digit writes and, on the field's last byte, queues a text job.
// ----------------------------------------------------------------------------
module pdt_front #(
  parameter int MAX_DIGITS = pdt_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [4:0]       cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output pdt_pkg::job_t    q_job,
  output pdt_pkg::dwr_t    dwr
);
  import pdt_pkg::*;

  localparam logic [5:0] MaxD = 6'(MAX_DIGITS);

  logic [4:0] int_r, frac_r;
  logic       sgn_r;
  logic [4:0] bc_r;
  logic       wr_bank_r;

  logic [5:0] sum;
  logic [4:0] total, fr, intd, len;
  logic       pad, is_last, accept;
  logic [5:0] pos, hi_idx, lo_idx;
  logic       hi_en, lo_en;
  logic [3:0] hi_nib, lo_nib;

  // Field geometry from the current registers
  always_comb begin
    sum     = {1'b0, int_r} + {1'b0, frac_r};
    total   = (sum > MaxD) ? MaxD[4:0] : sum[4:0];
    fr      = (frac_r > total) ? total : frac_r;
    intd    = total - fr;
    len     = {1'b0, total[4:1]} + 5'd1;
    pad     = ~total[0];
    is_last = ({1'b0, bc_r} + 6'd1) >= {1'b0, len};
  end

  assign accept    = in_tvalid & in_tready;
  assign in_tready = ~q_full;
  assign hi_nib    = in_tdata[7:4];
  assign lo_nib    = in_tdata[3:0];

  // Digit positions of the two nibbles
  always_comb begin
    pos = {bc_r, 1'b0};
    if (is_last) begin
      hi_idx = {1'b0, total} - 6'd1;
      lo_idx = '0;
      hi_en  = (total != 5'd0);
      lo_en  = 1'b0;
    end else begin
      hi_idx = pos - {5'd0, pad};
      lo_idx = pos + 6'd1 - {5'd0, pad};
      hi_en  = !(pad && (pos == 6'd0)) && (hi_idx < {1'b0, total});
      lo_en  = lo_idx < {1'b0, total};
    end
  end

  // Steer the nibbles to the even and odd banks
  always_comb begin
    dwr.bank    = wr_bank_r;
    dwr.ev_en   = 1'b0;
    dwr.ev_addr = '0;
    dwr.ev_data = '0;
    dwr.od_en   = 1'b0;
    dwr.od_addr = '0;
    dwr.od_data = '0;
    if (hi_en) begin
      if (hi_idx[0]) begin
        dwr.od_en   = accept;
        dwr.od_addr = hi_idx[BANK_AW:1];
        dwr.od_data = hi_nib;
      end else begin
        dwr.ev_en   = accept;
        dwr.ev_addr = hi_idx[BANK_AW:1];
        dwr.ev_data = hi_nib;
      end
    end
    if (lo_en) begin
      if (lo_idx[0]) begin
        dwr.od_en   = accept;
        dwr.od_addr = lo_idx[BANK_AW:1];
        dwr.od_data = lo_nib;
      end else begin
        dwr.ev_en   = accept;
        dwr.ev_addr = lo_idx[BANK_AW:1];
        dwr.ev_data = lo_nib;
      end
    end
  end

  // Job for the back end; an unsigned empty field gives no text
  assign q_push      = accept && is_last && (sgn_r || (total != 5'd0));
  assign q_job.bank  = wr_bank_r;
  assign q_job.sgn   = sgn_r;
  assign q_job.neg   = (lo_nib == NIB_NEG);
  assign q_job.intd  = intd;
  assign q_job.frac  = fr;
  assign q_job.total = total;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r  <= 5'd1;
      frac_r <= 5'd0;
      sgn_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTEGER_DIGITS:  int_r  <= cfg_wdata;
        CFG_FRACTION_DIGITS: frac_r <= cfg_wdata;
        CFG_SIGNED_FIELD:    sgn_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Byte count and digit bank selection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r      <= '0;
      wr_bank_r <= 1'b0;
    end else if (accept) begin
      bc_r <= is_last ? 5'd0 : bc_r + 5'd1;
      if (q_push) begin
        wr_bank_r <= ~wr_bank_r;
      end
    end
  end

endmodule

// ===== rtl/pdt_jobq.sv =====
// ----------------------------------------------------------------------------
// pdt_jobq: two-entry job queue
// Decouples byte intake from text output; the head stays until the back end
// has registered the field's last character for output.
// ----------------------------------------------------------------------------
module pdt_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pdt_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output pdt_pkg::job_t head
);
  import pdt_pkg::*;

  job_t       mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rp_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2 || pop))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0)
    else $error("job popped from empty queue");

endmodule

// ===== rtl/pdt_back.sv =====
// ----------------------------------------------------------------------------
// pdt_back: text emitter
// Holds the two-bank digit store and walks one job at a time through sign,
// integer digits, point and fraction digits, one character per beat.
// ----------------------------------------------------------------------------
module pdt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pdt_pkg::dwr_t dwr,
  input  logic          q_valid,
  input  pdt_pkg::job_t job,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);
  import pdt_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SIGN, ST_INT, ST_DOT, ST_FRAC} state_t;

  // Even and odd digit banks, two buffers each
  logic [3:0] ev_mem [0:1][0:BANK_DEPTH-1];
  logic [3:0] od_mem [0:1][0:BANK_DEPTH-1];

  state_t     state_r, state_nxt, first;
  logic [4:0] k_r, k_nxt;
  logic [4:0] rd_k;
  logic [5:0] k_inc;
  logic [3:0] digit_r;
  logic [7:0] ch;
  logic       last, step;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_char_r;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? {4'h3, nib} : (8'h57 + {4'h0, nib});
  endfunction

  assign k_inc = {1'b0, k_r} + 6'd1;
  assign step  = (state_r != ST_IDLE) && (!out_valid_r || out_tready);
  assign q_pop = step && last;

  // Digit index the sequencer works on in the next cycle
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_k = '0;
    end else if (step) begin
      rd_k = k_nxt;
    end else begin
      rd_k = k_r;
    end
  end

  // Digit writes from the front end; digit read one index ahead
  always_ff @(posedge clk) begin
    if (dwr.ev_en) ev_mem[dwr.bank][dwr.ev_addr] <= dwr.ev_data;
    if (dwr.od_en) od_mem[dwr.bank][dwr.od_addr] <= dwr.od_data;
    digit_r <= rd_k[0] ? od_mem[job.bank][rd_k[BANK_AW:1]]
                       : ev_mem[job.bank][rd_k[BANK_AW:1]];
  end

  // First section of a new job
  always_comb begin
    if (job.sgn)                first = ST_SIGN;
    else if (job.intd != 5'd0)  first = ST_INT;
    else                        first = ST_DOT;
  end

  // Character and next section
  always_comb begin
    ch        = CHAR_POINT;
    last      = 1'b0;
    state_nxt = ST_IDLE;
    k_nxt     = k_r;
    case (state_r)
      ST_SIGN: begin
        ch = job.neg ? CHAR_MINUS : CHAR_PLUS;
        if (job.intd != 5'd0) begin
          state_nxt = ST_INT;
          k_nxt     = '0;
        end else if (job.frac != 5'd0) begin
          state_nxt = ST_DOT;
        end else begin
          last = 1'b1;
        end
      end
      ST_INT: begin
        ch = hex_char(digit_r);
        if (k_inc < {1'b0, job.intd}) begin
          state_nxt = ST_INT;
          k_nxt     = k_inc[4:0];
        end else if (job.frac != 5'd0) begin
          state_nxt = ST_DOT;
        end else begin
          last = 1'b1;
        end
      end
      ST_DOT: begin
        ch        = CHAR_POINT;
        state_nxt = ST_FRAC;
        k_nxt     = job.intd;
      end
      ST_FRAC: begin
        ch = hex_char(digit_r);
        if (k_inc < {1'b0, job.total}) begin
          state_nxt = ST_FRAC;
          k_nxt     = k_inc[4:0];
        end else begin
          last = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_char_r  <= '0;
    end else begin
      if (state_r == ST_IDLE) begin
        if (q_valid) begin
          state_r <= first;
          k_r     <= '0;
        end
      end else if (step) begin
        state_r <= state_nxt;
        k_r     <= k_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        out_char_r  <= ch;
        out_last_r  <= last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  a_job_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> q_valid)
    else $error("emitter running without a job");

  a_int_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INT) |-> (k_r < job.intd))
    else $error("integer digit index out of range");

  a_dot_has_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DOT) |-> (job.frac != 5'd0))
    else $error("point emitted without fraction digits");

endmodule

// ===== rtl/packed_decimal_to_text_top.sv =====
// ----------------------------------------------------------------------------
// packed_decimal_to_text_top: packed-decimal (COMP-3) field to display text
// Takes field bytes and emits the sign, hex digits and point as ASCII.
// ----------------------------------------------------------------------------
// Bytes of a field are taken one per cycle while the job queue is not full,
// high nibble first; the field is (integer_digits + fraction_digits)/2 + 1
// bytes long, the digit total capped at MAX_DIGITS. Nothing comes out until
// the field's last byte; then its text follows at one character per cycle
// while the output is ready. The digit store holds two fields, so bytes of
// the next field stream in while the previous text is sent; input stalls
// only when both buffers hold fields still being sent. An unsigned field of
// zero digits produces no text. No clearing pass is needed after reset.
// Configuration is written between fields while the block is idle, a duty
// of the user, as the block itself has no check for it.
// ----------------------------------------------------------------------------
module packed_decimal_to_text_top #(
  parameter int MAX_DIGITS = pdt_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] text_char
  output logic       out_tlast   // end_of_text
);
  import pdt_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t q_job, head;
  dwr_t dwr;

  pdt_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job),
    .dwr       (dwr)
  );

  pdt_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head)
  );

  pdt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dwr        (dwr),
    .q_valid    (q_valid),
    .job        (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/tb_packed_decimal_to_text_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_decimal_to_text_top: self-checking bench for the COMP-3 text block
// Streams packed-decimal fields in under several digit-count and sign
// settings and predicts the ASCII text of each field. Every output beat is
// checked, character and end flag, in order. Both stream sides idle at
// random, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_packed_decimal_to_text_top;
  import pdt_pkg::*;

  // One expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // Predicts field text from accepted bytes and checks output beats
  class text_scoreboard;
    logic [4:0] int_digits  = 5'd1;
    logic [4:0] frac_digits = 5'd0;
    logic       sign_en     = 1'b0;
    logic [3:0] digits [32];
    int         byte_cnt    = 0;
    logic       neg         = 1'b0;
    text_beat_t text_q [$];
    int         errors      = 0;

    function void write_reg(input logic [1:0] idx, input logic [4:0] val);
      case (idx)
        CFG_INTEGER_DIGITS:  int_digits  = val;
        CFG_FRACTION_DIGITS: frac_digits = val;
        CFG_SIGNED_FIELD:    sign_en     = val[0];
        default: ;
      endcase
    endfunction

    // digit count, capped at the block's capacity
    function int digit_total();
      int t;
      t = int'(int_digits) + int'(frac_digits);
      return (t > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : t;
    endfunction

    function int field_bytes();
      return digit_total() / 2 + 1;
    endfunction

    function void store_digit(input int idx, input int total, input logic [3:0] nib);
      if (idx >= 0 && idx < total) digits[idx] = nib;
    endfunction

    function logic [7:0] hex_ascii(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib - 4'd10);
    endfunction

    function void push_char(input logic [7:0] c);
      text_beat_t t;
      t.ch   = c;
      t.last = 1'b0;
      text_q = {text_q, t};
    endfunction

    // One accepted byte: store digits, or emit the whole text on the last byte
    function void note_byte(input logic [7:0] b);
      int total, frac, intd, pos, n0;
      bit pad;
      total = digit_total();
      frac  = (int'(frac_digits) > total) ? total : int'(frac_digits);
      intd  = total - frac;
      pad   = (total % 2 == 0);
      if (byte_cnt + 1 < field_bytes()) begin
        pos = 2 * byte_cnt;
        if (!(pad && pos == 0)) store_digit(pos - int'(pad), total, b[7:4]);
        store_digit(pos + 1 - int'(pad), total, b[3:0]);
        byte_cnt++;
        return;
      end
      if (total >= 1) store_digit(total - 1, total, b[7:4]);
      neg      = (b[3:0] == NIB_NEG);
      byte_cnt = 0;
      n0       = text_q.size();
      if (sign_en) push_char(neg ? CHAR_MINUS : CHAR_PLUS);
      for (int k = 0; k < intd; k++) push_char(hex_ascii(digits[k]));
      if (frac > 0) begin
        push_char(CHAR_POINT);
        for (int k = intd; k < total; k++) push_char(hex_ascii(digits[k]));
      end
      if (text_q.size() > n0) text_q[text_q.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(input logic [7:0] ch, input logic last);
      text_beat_t e;
      if (text_q.size() == 0) begin
        $error("unexpected beat: text_char=%h end_of_text=%b", ch, last);
        errors++;
        return;
      end
      e = text_q.pop_front();
      if (ch !== e.ch) begin
        $error("text_char: expected %h, got %h", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("end_of_text: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_index  = CFG_INTEGER_DIGITS;
  logic [4:0] cfg_wdata  = 5'd0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  text_scoreboard sb = new();
  bit calm         = 1'b0;   // no random idling on either side while set
  int rx_hold_left = 0;      // requested output hold-off, in cycles
  int bytes_sent   = 0;

  packed_decimal_to_text_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Output side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // One byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Stop sending, let all text drain, then allow the block to settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.text_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the registers selected by mask (bit i = register index i)
  task automatic write_config(input logic [4:0] ii, input logic [4:0] ff,
                              input logic ss, input logic [2:0] mask);
    logic [4:0] val;
    logic [1:0] idx;
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        case (i)
          0: begin idx = CFG_INTEGER_DIGITS;  val = ii;          end
          1: begin idx = CFG_FRACTION_DIGITS; val = ff;          end
          default: begin idx = CFG_SIGNED_FIELD; val = {4'd0, ss}; end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [3:0] rand_digit();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 9));
  endfunction

  function automatic logic [3:0] rand_sign();
    case ($urandom_range(0, 3))
      0:       return 4'hc;
      1:       return NIB_NEG;
      2:       return 4'hf;
      default: return 4'($urandom());
    endcase
  endfunction

  function automatic logic [4:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd31;
      default: return 5'($urandom_range(0, 6));
    endcase
  endfunction

  // A field of the current length: mostly well-formed, sometimes raw noise
  task automatic send_field(input bit noise);
    int len;
    logic [3:0] lo;
    len = sb.field_bytes();
    for (int i = 0; i < len; i++) begin
      lo = (i == len - 1) ? rand_sign() : rand_digit();
      send_byte(noise ? 8'($urandom()) : {rand_digit(), lo});
    end
  endtask

  // Main sequence
  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: one integer digit, unsigned
    send_byte(8'h9c);
    send_byte(8'hfd);
    wait_drained();

    // empty unsigned field gives no text
    write_config(5'd0, 5'd0, 1'b0, 3'b011);
    send_byte(8'h5d);
    wait_drained();

    // empty signed field gives the sign alone
    write_config(5'd0, 5'd0, 1'b1, 3'b100);
    send_byte(8'h0d);
    send_byte(8'h0c);
    wait_drained();

    // digit overflow: both counts at maximum saturate to all-fraction
    write_config(5'd31, 5'd31, 1'b1, 3'b011);
    send_byte(8'h00);
    send_byte(8'hff);
    for (int i = 0; i < 13; i++) send_byte({rand_digit(), rand_digit()});
    send_byte(8'h9d);
    wait_drained();

    // odd total with integer and fraction parts
    write_config(5'd2, 5'd1, 1'b1, 3'b011);
    send_byte(8'h12);
    send_byte(8'h3d);
    wait_drained();

    // random phases
    phase = 0;
    while (bytes_sent < 290) begin
      write_config(pick_count(), pick_count(), 1'($urandom()), 3'($urandom_range(1, 7)));
      if (phase == 2) begin
        // output held off while the sender keeps going: input must back up
        write_config(5'd3, 5'd2, 1'b1, 3'b111);
        calm = 1'b1;
        rx_hold_left = 300;
        for (int f = 0; f < 8; f++) send_field(1'b0);
        calm = 1'b0;
      end else begin
        calm = (phase == 5);
        for (int f = $urandom_range(1, 6); f > 0; f--)
          send_field($urandom_range(0, 9) == 0);
        calm = 1'b0;
      end
      wait_drained();
      phase++;
    end

    repeat (40) @(posedge clk);
    if (sb.text_q.size() != 0) begin
      $error("%0d expected characters never arrived", sb.text_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
